// ===== rtl/dpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcr_pkg
// shared widths, types, register codes and helpers for the disc pair
// collision resolver
// ----------------------------------------------------------------------------
package dpcr_pkg;

	// field widths
	localparam int CW     = 24;            // coordinate / velocity, Q8.16
	localparam int DW     = CW + 1;        // difference of two coordinates
	localparam int MW     = 16;            // mass, Q8.8
	localparam int RW     = 23;            // radius, Q7.16
	localparam int EW     = 17;            // restitution, Q1.16
	localparam int MGW    = 23;            // contact margin
	localparam int MSW    = MW + 1;        // mass sum
	localparam int REACHW = DW;            // r1 + r2 + margin
	localparam int SQW    = 2 * DW;        // one product of two differences
	localparam int D2W    = SQW;           // squared centre distance
	localparam int PW     = SQW + 1;       // dot product, signed
	localparam int APW    = PW - 1;        // magnitude of dot product
	localparam int EPW    = EW + 1;        // 1 + e
	localparam int KW     = EPW + MW;      // (1 + e) * mass
	localparam int SEG    = 25;            // operand split for wide products
	localparam int PPW    = 2 * SEG;
	localparam int DNPW   = SEG + MSW;
	localparam int PCW    = APW + DW;      // |p| * |c|
	localparam int NSEG   = PCW / SEG;
	localparam int KSEG   = 17;
	localparam int NKSEG  = KW / KSEG;
	localparam int PARTW  = SEG + KSEG;
	localparam int NW     = PCW + KW;      // full numerator
	localparam int DENW   = D2W + MSW + 16; // d2 * msum * 2^16
	localparam int QBITS  = 41;            // quotient bits kept by the divider
	localparam int MAGW   = QBITS;         // capped correction magnitude
	localparam int SUMW   = MAGW + 2;      // velocity plus correction
	localparam int NLANE  = 4;
	localparam int DIV_LAT  = QBITS + 2;   // setup, one stage per bit, rounding
	localparam int BACK_LAT = 4 + DIV_LAT;

	localparam logic [MAGW-1:0] CORR_CAP = MAGW'(1) << (MAGW - 1);
	localparam logic [EPW-1:0]  E_ONE    = EPW'(65536);

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = MGW;
	localparam logic [CFG_IW-1:0] REG_RESTITUTION    = 1'b0;
	localparam logic [CFG_IW-1:0] REG_CONTACT_MARGIN = 1'b1;
	localparam logic [EW-1:0]     RESTITUTION_RST    = EW'(45875);
	localparam logic [MGW-1:0]    MARGIN_RST         = MGW'(4588);

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [MW-1:0]        mass_t;
	typedef logic [RW-1:0]        radius_t;

	// classified item handed from front to back
	typedef struct packed {
		coord_t          v1x;
		coord_t          v1y;
		coord_t          v2x;
		coord_t          v2y;
		logic            touching;
		logic            approaching;
		logic            degenerate;
		logic            skip;
		logic            neg_x;
		logic            neg_y;
		logic [APW-1:0]  ap;
		logic [DW-1:0]   acx;
		logic [DW-1:0]   acy;
		logic [D2W-1:0]  d2;
		logic [MSW-1:0]  msum;
		logic [KW-1:0]   k1;
		logic [KW-1:0]   k2;
	} item_t;

	// fields that ride alongside the divider
	typedef struct packed {
		coord_t v1x;
		coord_t v1y;
		coord_t v2x;
		coord_t v2y;
		logic   touching;
		logic   approaching;
		logic   degenerate;
		logic   skip;
		logic   neg_x;
		logic   neg_y;
	} side_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// saturate to a 24 bit signed velocity
	function automatic coord_t sat_vel(input logic signed [SUMW-1:0] v);
		coord_t r;
		if (v > SUMW'(signed'(coord_t'({1'b0, {(CW-1){1'b1}}})))) begin
			r = {1'b0, {(CW-1){1'b1}}};
		end else if (v < SUMW'(signed'(coord_t'({1'b1, {(CW-1){1'b0}}})))) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = coord_t'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/disc_pair_collision_resolve.sv =====
// ----------------------------------------------------------------------------
// disc_pair_collision_resolve
// contact test and restitution impulse for a pair of discs, fixed point
// ----------------------------------------------------------------------------
// path from input accept to output valid:
// 4 front stages, queue, 4 product stages, 43 divider stages, output reg
// throughput: one item per cycle when not stalled, set by the bit-per-stage divider pipeline
// a full queue stalls the front; a stalled output stalls the whole back end
// reset: asynchronous, clears valids and queue pointers and loads the
// restitution and contact margin registers with their defaults
module disc_pair_collision_resolve #(
	parameter int QUEUE_DEPTH = dpcr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dpcr_pkg::CFG_IW-1:0]  cfg_idx,
	input  logic [dpcr_pkg::CFG_DW-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dpcr_pkg::coord_t             first_x,
	input  dpcr_pkg::coord_t             first_y,
	input  dpcr_pkg::coord_t             first_vx,
	input  dpcr_pkg::coord_t             first_vy,
	input  dpcr_pkg::coord_t             second_x,
	input  dpcr_pkg::coord_t             second_y,
	input  dpcr_pkg::coord_t             second_vx,
	input  dpcr_pkg::coord_t             second_vy,
	input  dpcr_pkg::mass_t              first_mass,
	input  dpcr_pkg::mass_t              second_mass,
	input  dpcr_pkg::radius_t            first_radius,
	input  dpcr_pkg::radius_t            second_radius,
	output logic                         out_valid,
	input  logic                         out_ready,
	output dpcr_pkg::coord_t             new_first_vx,
	output dpcr_pkg::coord_t             new_first_vy,
	output dpcr_pkg::coord_t             new_second_vx,
	output dpcr_pkg::coord_t             new_second_vy,
	output logic                         touching,
	output logic                         approaching,
	output logic                         degenerate
);
	import dpcr_pkg::*;

	logic [EW-1:0]  restitution_q;
	logic [MGW-1:0] margin_q;

	logic   push_valid;
	item_t  push_item;
	item_t  head;
	qstat_t qstat;
	logic   pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= RESTITUTION_RST;
			margin_q      <= MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RESTITUTION:    restitution_q <= EW'(cfg_wdata);
				REG_CONTACT_MARGIN: margin_q      <= MGW'(cfg_wdata);
				default: ;
			endcase
		end
	end

	dpcr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_x        (first_x),
		.first_y        (first_y),
		.first_vx       (first_vx),
		.first_vy       (first_vy),
		.second_x       (second_x),
		.second_y       (second_y),
		.second_vx      (second_vx),
		.second_vy      (second_vy),
		.first_mass     (first_mass),
		.second_mass    (second_mass),
		.first_radius   (first_radius),
		.second_radius  (second_radius),
		.restitution    (restitution_q),
		.contact_margin (margin_q),
		.qstat          (qstat),
		.push_valid     (push_valid),
		.push_item      (push_item)
	);

	dpcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	dpcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_first_vx  (new_first_vx),
		.new_first_vy  (new_first_vy),
		.new_second_vx (new_second_vx),
		.new_second_vy (new_second_vy),
		.touching      (touching),
		.approaching   (approaching),
		.degenerate    (degenerate)
	);

endmodule

// ===== rtl/dpcr_front.sv =====
// ----------------------------------------------------------------------------
// dpcr_front
// accepts disc pairs, forms differences, distance, dot product and contact
// flags, and pushes a classified item into the queue
// ----------------------------------------------------------------------------
module dpcr_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  dpcr_pkg::coord_t         first_x,
	input  dpcr_pkg::coord_t         first_y,
	input  dpcr_pkg::coord_t         first_vx,
	input  dpcr_pkg::coord_t         first_vy,
	input  dpcr_pkg::coord_t         second_x,
	input  dpcr_pkg::coord_t         second_y,
	input  dpcr_pkg::coord_t         second_vx,
	input  dpcr_pkg::coord_t         second_vy,
	input  dpcr_pkg::mass_t          first_mass,
	input  dpcr_pkg::mass_t          second_mass,
	input  dpcr_pkg::radius_t        first_radius,
	input  dpcr_pkg::radius_t        second_radius,
	input  logic [dpcr_pkg::EW-1:0]  restitution,
	input  logic [dpcr_pkg::MGW-1:0] contact_margin,
	input  dpcr_pkg::qstat_t         qstat,
	output logic                     push_valid,
	output dpcr_pkg::item_t          push_item
);
	import dpcr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	logic signed [DW-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [REACHW-1:0]    reach_s1;
	logic [MSW-1:0]       msum_s1;
	logic [KW-1:0]        k1_s1, k2_s1;
	coord_t               v1x_s1, v1y_s1, v2x_s1, v2y_s1;

	logic signed [SQW-1:0] sqx_s2, sqy_s2, prx_s2, pry_s2;
	logic [D2W-1:0]        rr_s2;
	logic signed [DW-1:0]  dx_s2, dy_s2;
	logic [MSW-1:0]        msum_s2;
	logic [KW-1:0]         k1_s2, k2_s2;
	coord_t                v1x_s2, v1y_s2, v2x_s2, v2y_s2;

	logic [D2W-1:0]        d2_s3;
	logic signed [PW-1:0]  p_s3;
	logic                  touch_s3;
	logic signed [DW-1:0]  dx_s3, dy_s3;
	logic [MSW-1:0]        msum_s3;
	logic [KW-1:0]         k1_s3, k2_s3;
	coord_t                v1x_s3, v1y_s3, v2x_s3, v2y_s3;

	item_t                 item_s4;

	logic [D2W-1:0]        d2_c;
	logic [EPW-1:0]        ep_c;
	logic signed [PW-1:0]  pneg_c;
	logic signed [DW-1:0]  dxneg_c, dyneg_c;

	// whole front holds while the queue is full and the last stage waits
	assign adv        = !(v_s4 && qstat.full);
	assign in_ready   = adv;
	assign push_valid = v_s4 && !qstat.full;
	assign push_item  = item_s4;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: differences, reach, mass sum and mass factors
	assign ep_c = E_ONE + EPW'(restitution);

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= DW'(second_x) - DW'(first_x);
			dy_s1    <= DW'(second_y) - DW'(first_y);
			dvx_s1   <= DW'(second_vx) - DW'(first_vx);
			dvy_s1   <= DW'(second_vy) - DW'(first_vy);
			reach_s1 <= REACHW'(first_radius) + REACHW'(second_radius)
				+ REACHW'(contact_margin);
			msum_s1  <= MSW'(first_mass) + MSW'(second_mass);
			k1_s1    <= KW'(ep_c) * KW'(second_mass);
			k2_s1    <= KW'(ep_c) * KW'(first_mass);
			v1x_s1   <= first_vx;
			v1y_s1   <= first_vy;
			v2x_s1   <= second_vx;
			v2y_s1   <= second_vy;
		end
	end

	// stage 2: squares and dot product terms
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= dx_s1 * dx_s1;
			sqy_s2  <= dy_s1 * dy_s1;
			prx_s2  <= dx_s1 * dvx_s1;
			pry_s2  <= dy_s1 * dvy_s1;
			rr_s2   <= D2W'(reach_s1) * D2W'(reach_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			msum_s2 <= msum_s1;
			k1_s2   <= k1_s1;
			k2_s2   <= k2_s1;
			v1x_s2  <= v1x_s1;
			v1y_s2  <= v1y_s1;
			v2x_s2  <= v2x_s1;
			v2y_s2  <= v2y_s1;
		end
	end

	// stage 3: squared distance, dot product, contact test
	assign d2_c = D2W'(unsigned'(sqx_s2)) + D2W'(unsigned'(sqy_s2));

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s3    <= d2_c;
			p_s3     <= PW'(prx_s2) + PW'(pry_s2);
			touch_s3 <= d2_c <= rr_s2;
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			msum_s3  <= msum_s2;
			k1_s3    <= k1_s2;
			k2_s3    <= k2_s2;
			v1x_s3   <= v1x_s2;
			v1y_s3   <= v1y_s2;
			v2x_s3   <= v2x_s2;
			v2y_s3   <= v2y_s2;
		end
	end

	// stage 4: magnitudes and signs for the back end
	assign pneg_c  = -p_s3;
	assign dxneg_c = -dx_s3;
	assign dyneg_c = -dy_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s4.v1x         <= v1x_s3;
			item_s4.v1y         <= v1y_s3;
			item_s4.v2x         <= v2x_s3;
			item_s4.v2y         <= v2y_s3;
			item_s4.touching    <= touch_s3;
			item_s4.approaching <= p_s3[PW-1] || (p_s3 == '0);
			item_s4.degenerate  <= d2_s3 == '0;
			item_s4.skip        <= (d2_s3 == '0) || (msum_s3 == '0);
			item_s4.neg_x       <= p_s3[PW-1] ^ dx_s3[DW-1];
			item_s4.neg_y       <= p_s3[PW-1] ^ dy_s3[DW-1];
			item_s4.ap          <= p_s3[PW-1] ? APW'(pneg_c) : APW'(p_s3);
			item_s4.acx         <= dx_s3[DW-1] ? dxneg_c : dx_s3;
			item_s4.acy         <= dy_s3[DW-1] ? dyneg_c : dy_s3;
			item_s4.d2          <= d2_s3;
			item_s4.msum        <= msum_s3;
			item_s4.k1          <= k1_s3;
			item_s4.k2          <= k2_s3;
		end
	end

endmodule

// ===== rtl/dpcr_queue.sv =====
// ----------------------------------------------------------------------------
// dpcr_queue
// small first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module dpcr_queue #(
	parameter int DEPTH = dpcr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  dpcr_pkg::item_t  push_item,
	input  logic             pop,
	output dpcr_pkg::item_t  head,
	output dpcr_pkg::qstat_t qstat
);
	import dpcr_pkg::*;

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	item_t           mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign qstat.full  = count_q == CNTW'(DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNTW'(push_valid) - CNTW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (!qstat.full || pop))
		else $error("item pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("item popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/dpcr_div.sv =====
// ----------------------------------------------------------------------------
// dpcr_div
// pipelined restoring divider, one quotient bit per stage, four numerators
// over a shared denominator, rounded half up and capped
// ----------------------------------------------------------------------------
module dpcr_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [dpcr_pkg::NW-1:0]     num [dpcr_pkg::NLANE],
	input  logic [dpcr_pkg::DENW-1:0]   den,
	output logic [dpcr_pkg::MAGW-1:0]   mag [dpcr_pkg::NLANE]
);
	import dpcr_pkg::*;

	logic [DENW-1:0]  den_q [QBITS+1];
	logic [DENW-1:0]  rem_q [QBITS+1][NLANE];
	logic [QBITS-1:0] nl_q  [QBITS+1][NLANE];
	logic [QBITS-1:0] qt_q  [QBITS+1][NLANE];
	logic             ovr_q [QBITS+1][NLANE];
	logic [MAGW-1:0]  mag_q [NLANE];

	assign mag = mag_q;

	// setup: quotient of 2^QBITS or more is capped
	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= den;
			for (int l = 0; l < NLANE; l++) begin
				ovr_q[0][l] <= DENW'(num[l][NW-1:QBITS]) >= den;
				rem_q[0][l] <= DENW'(num[l][NW-1:QBITS]);
				nl_q[0][l]  <= num[l][QBITS-1:0];
				qt_q[0][l]  <= '0;
			end
		end
	end

	// one quotient bit per stage
	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				den_q[j] <= den_q[j-1];
			end
		end
		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			logic [DENW:0] t;
			logic [DENW:0] diff;
			logic          ge;
			assign t    = {rem_q[j-1][l], nl_q[j-1][l][QBITS-1]};
			assign diff = t - {1'b0, den_q[j-1]};
			assign ge   = t >= {1'b0, den_q[j-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j][l] <= ge ? DENW'(diff) : DENW'(t);
					nl_q[j][l]  <= nl_q[j-1][l] << 1;
					qt_q[j][l]  <= {qt_q[j-1][l][QBITS-2:0], ge};
					ovr_q[j][l] <= ovr_q[j-1][l];
				end
			end
		end
	end

	// rounding and cap
	for (genvar l = 0; l < NLANE; l++) begin : g_round
		logic [QBITS:0] qr;
		logic           rnd;
		assign rnd = {rem_q[QBITS][l], 1'b0} >= {1'b0, den_q[QBITS]};
		assign qr  = {1'b0, qt_q[QBITS][l]} + (QBITS+1)'(rnd);
		always_ff @(posedge clk) begin
			if (en) begin
				mag_q[l] <= (ovr_q[QBITS][l] || (qr > (QBITS+1)'(CORR_CAP)))
					? CORR_CAP : MAGW'(qr);
			end
		end
	end

endmodule

// ===== rtl/dpcr_back.sv =====
// ----------------------------------------------------------------------------
// dpcr_back
// takes classified items from the queue, builds numerators and denominator,
// divides, and applies the corrections with saturation
// ----------------------------------------------------------------------------
module dpcr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dpcr_pkg::item_t  head,
	input  dpcr_pkg::qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output dpcr_pkg::coord_t new_first_vx,
	output dpcr_pkg::coord_t new_first_vy,
	output dpcr_pkg::coord_t new_second_vx,
	output dpcr_pkg::coord_t new_second_vy,
	output logic             touching,
	output logic             approaching,
	output logic             degenerate
);
	import dpcr_pkg::*;

	logic adv;

	logic [BACK_LAT-1:0] vld_q;
	side_t               sb_q [BACK_LAT];

	logic [PPW-1:0]  ppx_lo_s1, ppx_hi_s1, ppy_lo_s1, ppy_hi_s1;
	logic [DNPW-1:0] dn_lo_s1, dn_hi_s1;
	logic [KW-1:0]   k1_s1, k2_s1;

	logic [PCW-1:0]  pcx_s2, pcy_s2;
	logic [DENW-1:0] den_s2;
	logic [KW-1:0]   k1_s2, k2_s2;

	logic [PCW-1:0]   lane_pc [NLANE];
	logic [KW-1:0]    lane_k  [NLANE];
	logic [PARTW-1:0] part_s3 [NLANE][NSEG][NKSEG];
	logic [DENW-1:0]  den_s3;

	logic [NW-1:0]   num_c  [NLANE];
	logic [NW-1:0]   num_s4 [NLANE];
	logic [DENW-1:0] den_s4;

	logic [MAGW-1:0] mag [NLANE];

	side_t                 sd;
	logic signed [SUMW-1:0] m0, m1, m2, m3;
	logic signed [SUMW-1:0] n1x, n1y, n2x, n2y;

	logic   out_valid_q;
	coord_t n1x_q, n1y_q, n2x_q, n2y_q;
	logic   touch_q, appr_q, degen_q;

	// the whole back end moves when the output register can take an item
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !qstat.empty;

	// valid and side fields alongside the arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BACK_LAT-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= '{v1x: head.v1x, v1y: head.v1y, v2x: head.v2x, v2y: head.v2y,
				touching: head.touching, approaching: head.approaching,
				degenerate: head.degenerate, skip: head.skip,
				neg_x: head.neg_x, neg_y: head.neg_y};
			for (int i = 1; i < BACK_LAT; i++) begin
				sb_q[i] <= sb_q[i-1];
			end
		end
	end

	// stage 1: partial products of |p| * |c| and d2 * msum
	always_ff @(posedge clk) begin
		if (adv) begin
			ppx_lo_s1 <= PPW'(head.ap[SEG-1:0]) * PPW'(head.acx);
			ppx_hi_s1 <= PPW'(head.ap[APW-1:SEG]) * PPW'(head.acx);
			ppy_lo_s1 <= PPW'(head.ap[SEG-1:0]) * PPW'(head.acy);
			ppy_hi_s1 <= PPW'(head.ap[APW-1:SEG]) * PPW'(head.acy);
			dn_lo_s1  <= DNPW'(head.d2[SEG-1:0]) * DNPW'(head.msum);
			dn_hi_s1  <= DNPW'(head.d2[D2W-1:SEG]) * DNPW'(head.msum);
			k1_s1     <= head.k1;
			k2_s1     <= head.k2;
		end
	end

	// stage 2: combine partials
	always_ff @(posedge clk) begin
		if (adv) begin
			pcx_s2 <= (PCW'(ppx_hi_s1) << SEG) + PCW'(ppx_lo_s1);
			pcy_s2 <= (PCW'(ppy_hi_s1) << SEG) + PCW'(ppy_lo_s1);
			den_s2 <= ((DENW'(dn_hi_s1) << SEG) + DENW'(dn_lo_s1)) << 16;
			k1_s2  <= k1_s1;
			k2_s2  <= k2_s1;
		end
	end

	// stage 3: partial products of the numerators
	assign lane_pc[0] = pcx_s2;
	assign lane_pc[1] = pcy_s2;
	assign lane_pc[2] = pcx_s2;
	assign lane_pc[3] = pcy_s2;
	assign lane_k[0]  = k1_s2;
	assign lane_k[1]  = k1_s2;
	assign lane_k[2]  = k2_s2;
	assign lane_k[3]  = k2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s3 <= den_s2;
			for (int l = 0; l < NLANE; l++) begin
				for (int i = 0; i < NSEG; i++) begin
					for (int j = 0; j < NKSEG; j++) begin
						part_s3[l][i][j] <= PARTW'(lane_pc[l][i*SEG +: SEG])
							* PARTW'(lane_k[l][j*KSEG +: KSEG]);
					end
				end
			end
		end
	end

	// stage 4: sum partials into full numerators
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			num_c[l] = '0;
			for (int i = 0; i < NSEG; i++) begin
				for (int j = 0; j < NKSEG; j++) begin
					num_c[l] = num_c[l] + (NW'(part_s3[l][i][j]) << (i*SEG + j*KSEG));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4 <= den_s3;
			num_s4 <= num_c;
		end
	end

	dpcr_div u_div (
		.clk (clk),
		.en  (adv),
		.num (num_s4),
		.den (den_s4),
		.mag (mag)
	);

	// signed corrections and saturation
	assign sd = sb_q[BACK_LAT-1];
	assign m0 = signed'({2'b00, mag[0]});
	assign m1 = signed'({2'b00, mag[1]});
	assign m2 = signed'({2'b00, mag[2]});
	assign m3 = signed'({2'b00, mag[3]});

	always_comb begin
		n1x = SUMW'(sd.v1x);
		n1y = SUMW'(sd.v1y);
		n2x = SUMW'(sd.v2x);
		n2y = SUMW'(sd.v2y);
		if (!sd.skip) begin
			n1x = sd.neg_x ? n1x - m0 : n1x + m0;
			n1y = sd.neg_y ? n1y - m1 : n1y + m1;
			n2x = sd.neg_x ? n2x + m2 : n2x - m2;
			n2y = sd.neg_y ? n2y + m3 : n2y - m3;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_q[BACK_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n1x_q   <= sat_vel(n1x);
			n1y_q   <= sat_vel(n1y);
			n2x_q   <= sat_vel(n2x);
			n2y_q   <= sat_vel(n2y);
			touch_q <= sd.touching;
			appr_q  <= sd.approaching;
			degen_q <= sd.degenerate;
		end
	end

	assign out_valid     = out_valid_q;
	assign new_first_vx  = n1x_q;
	assign new_first_vy  = n1y_q;
	assign new_second_vx = n2x_q;
	assign new_second_vy = n2y_q;
	assign touching      = touch_q;
	assign approaching   = appr_q;
	assign degenerate    = degen_q;

endmodule

// ===== test/tb_disc_pair_collision_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disc_pair_collision_resolve
// streams disc pairs through the resolver under several restitution and
// margin settings with random stalls on both sides, predicts every result
// in wide integer arithmetic and compares field by field in order
// ----------------------------------------------------------------------------
module tb_disc_pair_collision_resolve;
	import dpcr_pkg::*;

	typedef struct packed {
		coord_t  first_x;
		coord_t  first_y;
		coord_t  first_vx;
		coord_t  first_vy;
		coord_t  second_x;
		coord_t  second_y;
		coord_t  second_vx;
		coord_t  second_vy;
		mass_t   first_mass;
		mass_t   second_mass;
		radius_t first_radius;
		radius_t second_radius;
	} pair_t;

	typedef struct packed {
		coord_t n1x;
		coord_t n1y;
		coord_t n2x;
		coord_t n2y;
		logic   touching;
		logic   approaching;
		logic   degenerate;
	} impact_t;

	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_idx = REG_RESTITUTION;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	pair_t drv = '0;
	impact_t got;

	pair_t   pending_pairs[$];
	impact_t expected_impacts[$];
	logic [16:0] restitution_q = 17'd45875;
	logic [22:0] margin_q = 23'd4588;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fails = 0;
	int cycles = 0;

	disc_pair_collision_resolve u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_x(drv.first_x), .first_y(drv.first_y),
		.first_vx(drv.first_vx), .first_vy(drv.first_vy),
		.second_x(drv.second_x), .second_y(drv.second_y),
		.second_vx(drv.second_vx), .second_vy(drv.second_vy),
		.first_mass(drv.first_mass), .second_mass(drv.second_mass),
		.first_radius(drv.first_radius), .second_radius(drv.second_radius),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_first_vx(got.n1x), .new_first_vy(got.n1y),
		.new_second_vx(got.n2x), .new_second_vy(got.n2y),
		.touching(got.touching), .approaching(got.approaching),
		.degenerate(got.degenerate)
	);

	// clock
	always #10 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// rounded, capped, signed impulse term k * p * c / den
	function automatic logic signed [63:0] impulse_term(input logic [63:0] k,
			input logic signed [63:0] p, input logic signed [63:0] c,
			input logic [127:0] den);
		logic [127:0] ap;
		logic [127:0] ac;
		logic [127:0] num;
		logic [127:0] q;
		logic [127:0] rm;
		ap = (p < 0) ? -p : p;
		ac = (c < 0) ? -c : c;
		num = ap * ac * {64'd0, k};
		q = num / den;
		rm = num % den;
		if ((rm << 1) >= den) q = q + 1;
		if (q > (128'd1 << 40)) q = 128'd1 << 40;
		return ((p < 0) != (c < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic coord_t clamp_vel(input logic signed [63:0] v);
		if (v > 64'sd8388607) return 24'sh7fffff;
		if (v < -64'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	// post-impact velocities and contact flags
	function automatic impact_t resolve_pair(input pair_t a);
		logic signed [63:0] x1 = a.first_x;
		logic signed [63:0] y1 = a.first_y;
		logic signed [63:0] v1x = a.first_vx;
		logic signed [63:0] v1y = a.first_vy;
		logic signed [63:0] x2 = a.second_x;
		logic signed [63:0] y2 = a.second_y;
		logic signed [63:0] v2x = a.second_vx;
		logic signed [63:0] v2y = a.second_vy;
		logic signed [63:0] dx, dy, p;
		logic signed [63:0] n1x, n1y, n2x, n2y;
		logic [63:0] d2, reach, msum, k1, k2;
		logic [127:0] den;
		impact_t r;
		dx = x2 - x1;
		dy = y2 - y1;
		d2 = dx * dx + dy * dy;
		p = dx * (v2x - v1x) + dy * (v2y - v1y);
		reach = 64'(a.first_radius) + 64'(a.second_radius) + 64'(margin_q);
		msum = 64'(a.first_mass) + 64'(a.second_mass);
		n1x = v1x; n1y = v1y; n2x = v2x; n2y = v2y;
		if (d2 != 0 && msum != 0) begin
			den = {64'd0, d2} * {64'd0, msum << 16};
			k1 = (64'd65536 + 64'(restitution_q)) * 64'(a.second_mass);
			k2 = (64'd65536 + 64'(restitution_q)) * 64'(a.first_mass);
			n1x = n1x + impulse_term(k1, p, dx, den);
			n1y = n1y + impulse_term(k1, p, dy, den);
			n2x = n2x - impulse_term(k2, p, dx, den);
			n2y = n2y - impulse_term(k2, p, dy, den);
		end
		r.n1x = clamp_vel(n1x);
		r.n1y = clamp_vel(n1y);
		r.n2x = clamp_vel(n2x);
		r.n2y = clamp_vel(n2y);
		r.touching = (d2 <= reach * reach);
		r.approaching = (p <= 0);
		r.degenerate = (d2 == 0);
		return r;
	endfunction

	// driver: present pending items, predict each accepted one
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_impacts.push_back(resolve_pair(drv));
		end
		if (!in_valid || in_ready) begin
			if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv <= pending_pairs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: random back pressure, compare against oldest expectation
	always @(posedge clk) begin
		impact_t e;
		if (out_valid && out_ready) begin
			if (expected_impacts.size() == 0) begin
				$error("unexpected item out");
				fails = fails + 1;
			end else begin
				e = expected_impacts.pop_front();
				if (got.n1x !== e.n1x) begin
					$error("new_first_vx exp %0d got %0d", e.n1x, got.n1x);
					fails = fails + 1;
				end
				if (got.n1y !== e.n1y) begin
					$error("new_first_vy exp %0d got %0d", e.n1y, got.n1y);
					fails = fails + 1;
				end
				if (got.n2x !== e.n2x) begin
					$error("new_second_vx exp %0d got %0d", e.n2x, got.n2x);
					fails = fails + 1;
				end
				if (got.n2y !== e.n2y) begin
					$error("new_second_vy exp %0d got %0d", e.n2y, got.n2y);
					fails = fails + 1;
				end
				if (got.touching !== e.touching) begin
					$error("touching exp %0b got %0b", e.touching, got.touching);
					fails = fails + 1;
				end
				if (got.approaching !== e.approaching) begin
					$error("approaching exp %0b got %0b", e.approaching, got.approaching);
					fails = fails + 1;
				end
				if (got.degenerate !== e.degenerate) begin
					$error("degenerate exp %0b got %0b", e.degenerate, got.degenerate);
					fails = fails + 1;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic pair_t build_pair(input int x1, input int y1, input int vx1,
			input int vy1, input int x2, input int y2, input int vx2, input int vy2,
			input int m1, input int m2, input int r1, input int r2);
		pair_t a;
		a.first_x = CW'(x1); a.first_y = CW'(y1);
		a.first_vx = CW'(vx1); a.first_vy = CW'(vy1);
		a.second_x = CW'(x2); a.second_y = CW'(y2);
		a.second_vx = CW'(vx2); a.second_vy = CW'(vy2);
		a.first_mass = MW'(m1); a.second_mass = MW'(m2);
		a.first_radius = RW'(r1); a.second_radius = RW'(r2);
		return a;
	endfunction

	// mostly pairs near contact, some full range noise
	function automatic pair_t random_pair();
		pair_t a;
		int x1, y1, sc;
		if ($urandom_range(99) < 25) begin
			a.first_x = CW'($urandom); a.first_y = CW'($urandom);
			a.first_vx = CW'($urandom); a.first_vy = CW'($urandom);
			a.second_x = CW'($urandom); a.second_y = CW'($urandom);
			a.second_vx = CW'($urandom); a.second_vy = CW'($urandom);
			a.first_radius = RW'($urandom); a.second_radius = RW'($urandom);
		end else begin
			sc = 1 << $urandom_range(4, 20);
			x1 = int'($urandom_range(0, 1 << 22)) - (1 << 21);
			y1 = int'($urandom_range(0, 1 << 22)) - (1 << 21);
			a.first_x = CW'(x1); a.first_y = CW'(y1);
			a.second_x = CW'(x1 + int'($urandom_range(0, 2 * sc)) - sc);
			a.second_y = CW'(y1 + int'($urandom_range(0, 2 * sc)) - sc);
			a.first_vx = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			a.first_vy = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			a.second_vx = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			a.second_vy = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			a.first_radius = RW'($urandom_range(0, sc));
			a.second_radius = RW'($urandom_range(0, sc));
		end
		a.first_mass = MW'($urandom_range(1, 65535));
		a.second_mass = MW'($urandom_range(1, 65535));
		return a;
	endfunction

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [22:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RESTITUTION) restitution_q = val[16:0];
		else margin_q = val;
	endtask

	task automatic wait_idle();
		while (pending_pairs.size() != 0 || in_valid || expected_impacts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	logic [22:0] e_set[6] = '{23'd45875, 23'd0, 23'd65536, 23'd131071, 23'd32768, 23'd65536};
	logic [22:0] m_set[6] = '{23'd4588, 23'd0, 23'd8388607, 23'd1000, 23'd77777, 23'd0};

	// stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 65 : 0;
			recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 33 : 0;
			write_reg(REG_RESTITUTION, e_set[ph]);
			write_reg(REG_CONTACT_MARGIN, (ph == 4) ? 23'($urandom) : m_set[ph]);
			@(negedge clk);
			if (ph == 0) begin
				// coinciding centres
				pending_pairs.push_back(build_pair(100, 200, 5000, -300, 100, 200,
					-4000, 700, 256, 512, 65536, 65536));
				// all fields at their top
				pending_pairs.push_back(build_pair(8388607, 8388607, 8388607, 8388607,
					8388607, 8388607, 8388607, 8388607, 65535, 65535, 8388607, 8388607));
				// all fields at their bottom, masses at one
				pending_pairs.push_back(build_pair(-8388608, -8388608, -8388608,
					-8388608, -8388608, -8388608, -8388608, -8388608, 1, 1, 0, 0));
				// opposite corners, max speeds toward each other
				pending_pairs.push_back(build_pair(-8388608, -8388608, 8388607, 8388607,
					8388607, 8388607, -8388608, -8388608, 1, 65535, 8388607, 0));
				// head-on, equal masses
				pending_pairs.push_back(build_pair(0, 0, 65536, 0, 131072, 0,
					-65536, 0, 256, 256, 65536, 65536));
				// receding
				pending_pairs.push_back(build_pair(0, 0, -65536, 0, 131072, 0,
					65536, 0, 256, 256, 65536, 65536));
				// purely tangential motion
				pending_pairs.push_back(build_pair(0, 0, 0, 65536, 131072, 0,
					0, -65536, 300, 700, 65536, 65536));
				// far apart with zero radii
				pending_pairs.push_back(build_pair(-4000000, 0, 1000, 0, 4000000, 0,
					-1000, 0, 256, 256, 0, 0));
				// huge correction, centres one lsb apart
				pending_pairs.push_back(build_pair(0, 0, 8388607, -8388608, 1, 0,
					-8388608, 8388607, 65535, 1, 1, 1));
				pending_pairs.push_back(build_pair(5, 5, 8388607, 8388607, 6, 6,
					-8388608, -8388608, 1, 65535, 0, 0));
				// extreme mass ratios
				pending_pairs.push_back(build_pair(0, 0, 200000, 30000, 90000, 40000,
					-100000, 0, 65535, 1, 50000, 50000));
				pending_pairs.push_back(build_pair(0, 0, 200000, 30000, 90000, 40000,
					-100000, 0, 1, 65535, 50000, 50000));
			end
			for (int i = 0; i < 106; i++) pending_pairs.push_back(random_pair());
			wait_idle();
		end
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== disc_pair_collision_resolve.f =====
rtl/dpcr_pkg.sv
rtl/dpcr_front.sv
rtl/dpcr_queue.sv
rtl/dpcr_div.sv
rtl/dpcr_back.sv
rtl/disc_pair_collision_resolve.sv
test/tb_disc_pair_collision_resolve.sv
